/* rtl/arc_pkg.sv */
// Shared types and constants for the audio rate converter.
// No dependencies; used by arc_ctrl, arc_dp and audio_rate_converter.
package arc_pkg;

    localparam int MAX_CHANNELS = 2;
    localparam int CNT_W        = 26;   // element counters, wrap at 2^26
    localparam int FRAMES_W     = 24;
    localparam int STEP_W       = 12;
    localparam int FRAC_W       = 8;
    localparam int SAMPLE_W     = 16;
    localparam int HIST_DEPTH   = 4;
    localparam int HIST_AW      = 2;
    localparam int CFG_AW       = 2;
    localparam int CFG_DW       = 24;
    localparam int BURST_W      = 5;
    localparam logic [BURST_W-1:0] BURST_LEN = 5'd16;

    typedef enum logic [CFG_AW-1:0] {
        REG_CHANNEL_COUNT   = 2'd0,
        REG_EIGHT_BIT_INPUT = 2'd1,
        REG_FRAC_STEP       = 2'd2,
        REG_OUTPUT_COUNT    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;   // take the accepted input beat into history
        logic emit;   // produce one output frame into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic frame_ready;  // a frame's elements are all present and sound not done
        logic out_free;     // output register can take a new frame this cycle
    } dp_status_t;

endpackage

/* rtl/arc_ctrl.sv */
// Controller for the audio rate converter: accept/emit sequencing and burst count.
// Depends on arc_pkg.
module arc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  arc_pkg::dp_status_t status,
    output arc_pkg::dp_cmd_t    cmd
);

    arc_pkg::ctrl_state_t state_reg, state_next;
    logic [arc_pkg::BURST_W-1:0] burst_reg, burst_next;
    logic burst_done;

    assign burst_done = (burst_reg == arc_pkg::BURST_LEN);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            arc_pkg::ST_IDLE: begin
                if (s_valid) state_next = arc_pkg::ST_EMIT;
            end
            arc_pkg::ST_EMIT: begin
                if (!status.frame_ready || burst_done) state_next = arc_pkg::ST_IDLE;
            end
            default: state_next = arc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        case (state_reg)
            arc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            arc_pkg::ST_EMIT: begin
                cmd.emit = status.frame_ready && !burst_done && status.out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        burst_next = burst_reg;
        if (cmd.load)      burst_next = '0;
        else if (cmd.emit) burst_next = burst_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= arc_pkg::ST_IDLE;
            burst_reg <= '0;
        end else begin
            state_reg <= state_next;
            burst_reg <= burst_next;
        end
    end

endmodule

/* rtl/arc_dp.sv */
// Datapath for the audio rate converter: config registers, sample history,
// position counters and the output register. Depends on arc_pkg.
module arc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [arc_pkg::CFG_AW-1:0]          cfg_index,
    input  logic [arc_pkg::CFG_DW-1:0]          cfg_wdata,
    input  logic                                in_start,
    input  logic [arc_pkg::SAMPLE_W-1:0]        in_raw_first,
    input  logic [arc_pkg::SAMPLE_W-1:0]        in_raw_second,
    input  arc_pkg::dp_cmd_t                    cmd,
    output arc_pkg::dp_status_t                 status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [arc_pkg::SAMPLE_W-1:0] m_out_first,
    output logic signed [arc_pkg::SAMPLE_W-1:0] m_out_second,
    output logic                                m_last_frame
);

    localparam int CW = arc_pkg::CNT_W;
    localparam int SW = arc_pkg::SAMPLE_W;

    // configuration
    logic [1:0]                      chan_reg;
    logic                            eight_reg;
    logic [arc_pkg::STEP_W-1:0]      step_reg;
    logic [arc_pkg::FRAMES_W-1:0]    total_reg;

    // sound state
    logic [SW-1:0]                   hist_reg [arc_pkg::HIST_DEPTH];
    logic [SW-1:0]                   hist_next [arc_pkg::HIST_DEPTH];
    logic [CW-1:0]                   erx_reg, erx_next;
    logic [CW-1:0]                   rp_reg, rp_next;
    logic [arc_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic [arc_pkg::FRAMES_W-1:0]    emitted_reg, emitted_next;

    // output register
    logic                            m_valid_reg;
    logic [SW-1:0]                   first_reg, second_reg;
    logic                            last_reg;

    logic                            stereo;
    logic [SW-1:0]                   conv_first, conv_second;
    logic [CW-1:0]                   erx_base;
    logic [arc_pkg::FRAMES_W-1:0]    emitted_base;
    logic                            finished_on_load;
    logic [arc_pkg::HIST_AW-1:0]     wr_slot0, wr_slot1;
    logic [CW-1:0]                   lead;
    logic [arc_pkg::FRAMES_W-1:0]    emitted_inc;
    logic [arc_pkg::STEP_W:0]        step_sum;
    logic [arc_pkg::HIST_AW-1:0]     rd_slot0, rd_slot1;

    // channel count 0 acts as 1, above the maximum acts as the maximum
    assign stereo = (chan_reg >= 2'(arc_pkg::MAX_CHANNELS)) && (arc_pkg::MAX_CHANNELS == 2);

    // byte b becomes (b - 128) << 8: flip the top bit
    assign conv_first  = eight_reg ? {in_raw_first[7:0] ^ 8'h80, 8'h00} : in_raw_first;
    assign conv_second = eight_reg ? {in_raw_second[7:0] ^ 8'h80, 8'h00} : in_raw_second;

    assign erx_base         = in_start ? '0 : erx_reg;
    assign emitted_base     = in_start ? '0 : emitted_reg;
    assign finished_on_load = (emitted_base >= total_reg);
    assign wr_slot0         = erx_base[arc_pkg::HIST_AW-1:0];
    assign wr_slot1         = wr_slot0 + 1'b1;

    // frame ready: signed lead is non-negative and covers the channel count
    assign lead = erx_reg - rp_reg;
    assign status.frame_ready = !lead[CW-1] && (lead >= (stereo ? CW'(2) : CW'(1)))
                                && (emitted_reg < total_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

    assign emitted_inc = emitted_reg + 1'b1;
    assign step_sum    = {1'b0, {(arc_pkg::STEP_W - arc_pkg::FRAC_W){1'b0}}, frac_reg}
                         + {1'b0, step_reg};
    assign rd_slot0    = rp_reg[arc_pkg::HIST_AW-1:0];
    assign rd_slot1    = rd_slot0 + 1'b1;

    always_comb begin
        for (int i = 0; i < arc_pkg::HIST_DEPTH; i++) begin
            hist_next[i] = hist_reg[i];
        end
        erx_next     = erx_reg;
        rp_next      = rp_reg;
        frac_next    = frac_reg;
        emitted_next = emitted_reg;
        if (cmd.load) begin
            if (in_start) begin
                for (int i = 0; i < arc_pkg::HIST_DEPTH; i++) begin
                    hist_next[i] = '0;
                end
                rp_next   = '0;
                frac_next = '0;
            end
            emitted_next = emitted_base;
            erx_next     = erx_base;
            if (!finished_on_load) begin
                hist_next[wr_slot0] = conv_first;
                if (stereo) hist_next[wr_slot1] = conv_second;
                erx_next = erx_base + (stereo ? CW'(2) : CW'(1));
            end
        end else if (cmd.emit) begin
            emitted_next = emitted_inc;
            rp_next      = rp_reg + CW'(step_sum[arc_pkg::STEP_W:arc_pkg::FRAC_W]);
            frac_next    = step_sum[arc_pkg::FRAC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg    <= 2'd1;
            eight_reg   <= 1'b0;
            step_reg    <= 12'd256;
            total_reg   <= '0;
            erx_reg     <= '0;
            rp_reg      <= '0;
            frac_reg    <= '0;
            emitted_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < arc_pkg::HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (arc_pkg::cfg_reg_t'(cfg_index))
                    arc_pkg::REG_CHANNEL_COUNT:   chan_reg  <= cfg_wdata[1:0];
                    arc_pkg::REG_EIGHT_BIT_INPUT: eight_reg <= cfg_wdata[0];
                    arc_pkg::REG_FRAC_STEP:       step_reg  <= cfg_wdata[arc_pkg::STEP_W-1:0];
                    arc_pkg::REG_OUTPUT_COUNT:    total_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            erx_reg     <= erx_next;
            rp_reg      <= rp_next;
            frac_reg    <= frac_next;
            emitted_reg <= emitted_next;
            for (int i = 0; i < arc_pkg::HIST_DEPTH; i++) begin
                hist_reg[i] <= hist_next[i];
            end
            if (cmd.emit)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            first_reg  <= hist_reg[rd_slot0];
            second_reg <= stereo ? hist_reg[rd_slot1] : '0;
            last_reg   <= (emitted_inc == total_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_first  = signed'(first_reg);
    assign m_out_second = signed'(second_reg);
    assign m_last_frame = last_reg;

endmodule

/* rtl/audio_rate_converter.sv */
// Nearest-neighbor audio rate converter, top level.
// Input beats carry one interleaved source frame (s_ channel); output beats carry
// one 16-bit signed output frame (m_ channel); both are valid/ready.
// Config: cfg_wr_en/cfg_index/cfg_wdata write channel_count (0), eight_bit_input (1),
// frac_step (2, 4.8 step) and output_count (3); write only while the block is idle.
// An input beat is taken in the idle state; the next cycle starts a burst that
// emits every output frame whose elements have arrived, one per cycle while the
// output register is free. The first frame is registered into the output register
// once the controller has moved from idle to the emit state; the single emit loop
// advances the read position once per frame, up to 16 frames per input beat.
// s_ready is low during the burst. If the receiver stalls, the burst pauses with
// the current frame held in the output register; a held frame does not block
// acceptance of the next input beat once the burst is over.
// m_last_frame marks frame number output_count; later inputs are dropped until a
// beat with s_start_of_sound. Reset (aresetn low, synchronous) restores the config
// defaults, clears history and counters and empties the output register.
// Depends on arc_pkg, arc_ctrl, arc_dp.
module audio_rate_converter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [arc_pkg::CFG_AW-1:0]          cfg_index,
    input  logic [arc_pkg::CFG_DW-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_of_sound,
    input  logic [arc_pkg::SAMPLE_W-1:0]        s_raw_first,
    input  logic [arc_pkg::SAMPLE_W-1:0]        s_raw_second,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [arc_pkg::SAMPLE_W-1:0] m_out_first,
    output logic signed [arc_pkg::SAMPLE_W-1:0] m_out_second,
    output logic                                m_last_frame
);

    arc_pkg::dp_cmd_t    cmd;
    arc_pkg::dp_status_t status;

    arc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    arc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_start      (s_start_of_sound),
        .in_raw_first  (s_raw_first),
        .in_raw_second (s_raw_second),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_first   (m_out_first),
        .m_out_second  (m_out_second),
        .m_last_frame  (m_last_frame)
    );

    // a frame is only pushed into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("emit into occupied output register");

    // in the cycle after an accepted beat the block is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted back to back");

    // load and emit never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.emit))
        else $error("load and emit in same cycle");

    // an emit always shows up as a valid output beat next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid)
        else $error("emitted frame not presented");

endmodule

/* test/audio_rate_converter_test.sv */
// Self-checking testbench for audio_rate_converter: directed and random sounds,
// random idle on both channels, checked against an in-bench resampler predictor.
// Depends on arc_pkg and the audio_rate_converter RTL.
module audio_rate_converter_test;

    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_TARGET = 110;

    typedef struct packed {
        logic signed [arc_pkg::SAMPLE_W-1:0] first;
        logic signed [arc_pkg::SAMPLE_W-1:0] second;
        logic                                last;
    } pcm_frame_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    arc_pkg::cfg_reg_t                   cfg_index;
    logic [arc_pkg::CFG_DW-1:0]          cfg_wdata;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_start_of_sound;
    logic [arc_pkg::SAMPLE_W-1:0]        s_raw_first;
    logic [arc_pkg::SAMPLE_W-1:0]        s_raw_second;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [arc_pkg::SAMPLE_W-1:0] m_out_first;
    logic signed [arc_pkg::SAMPLE_W-1:0] m_out_second;
    logic                                m_last_frame;

    // predictor copy of the registers and the sound state
    logic [1:0]                   cfg_channels;
    logic                         cfg_bytes;
    logic [arc_pkg::STEP_W-1:0]   cfg_step;
    logic [arc_pkg::FRAMES_W-1:0] cfg_frames;
    logic [arc_pkg::SAMPLE_W-1:0] hist [arc_pkg::HIST_DEPTH];
    logic [arc_pkg::CNT_W-1:0]    elems_in;
    logic [arc_pkg::CNT_W-1:0]    read_pos;
    logic [arc_pkg::FRAC_W-1:0]   pos_frac;
    logic [arc_pkg::FRAMES_W-1:0] frames_out;

    pcm_frame_t  frames_due [$];
    int unsigned items_sent;
    int unsigned mismatches;
    int unsigned beats_left;
    bit          hold_flip;

    audio_rate_converter uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_of_sound (s_start_of_sound),
        .s_raw_first      (s_raw_first),
        .s_raw_second     (s_raw_second),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_first      (m_out_first),
        .m_out_second     (m_out_second),
        .m_last_frame     (m_last_frame)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [arc_pkg::SAMPLE_W-1:0] to_pcm(
        input logic [arc_pkg::SAMPLE_W-1:0] raw);
        // unsigned byte: flip the sign bit and move it to the top
        return cfg_bytes ? {raw[7:0] ^ 8'h80, 8'h00} : raw;
    endfunction

    task automatic clear_sound();
        for (int i = 0; i < arc_pkg::HIST_DEPTH; i++) hist[i] = '0;
        elems_in   = '0;
        read_pos   = '0;
        pos_frac   = '0;
        frames_out = '0;
    endtask

    task automatic predict_frames(input logic sos, input logic [arc_pkg::SAMPLE_W-1:0] raw_a,
                                  input logic [arc_pkg::SAMPLE_W-1:0] raw_b);
        logic [1:0]                nch;
        logic [arc_pkg::CNT_W-1:0] lead;
        logic [12:0]               total;
        int unsigned               burst;
        pcm_frame_t                f;
        nch = (cfg_channels == 2'd0) ? 2'd1 :
              (cfg_channels > arc_pkg::MAX_CHANNELS) ? 2'(arc_pkg::MAX_CHANNELS) :
              cfg_channels;
        if (sos) clear_sound();
        if (frames_out >= cfg_frames) return;
        hist[elems_in[1:0]] = to_pcm(raw_a);
        elems_in++;
        if (nch == 2'd2) begin
            hist[elems_in[1:0]] = to_pcm(raw_b);
            elems_in++;
        end
        burst = 0;
        while (burst < arc_pkg::BURST_LEN && frames_out < cfg_frames) begin
            lead = elems_in - read_pos;
            if (lead[arc_pkg::CNT_W-1] || lead < nch) break;
            f.first  = hist[read_pos[1:0]];
            f.second = (nch == 2'd2) ? hist[read_pos[1:0] + 2'd1] : '0;
            frames_out++;
            f.last = (frames_out == cfg_frames);
            frames_due.push_back(f);
            burst++;
            total    = pos_frac + cfg_step;
            read_pos = read_pos + total[12:8];
            pos_frac = total[7:0];
        end
    endtask

    // leaves cfg_wr_en high; the caller lowers it after the last write
    task automatic write_reg(input arc_pkg::cfg_reg_t idx,
                             input logic [arc_pkg::CFG_DW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            arc_pkg::REG_CHANNEL_COUNT:   cfg_channels = value[1:0];
            arc_pkg::REG_EIGHT_BIT_INPUT: cfg_bytes    = value[0];
            arc_pkg::REG_FRAC_STEP:       cfg_step     = value[arc_pkg::STEP_W-1:0];
            arc_pkg::REG_OUTPUT_COUNT:    cfg_frames   = value[arc_pkg::FRAMES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [1:0] channels, input logic bytes,
                                input logic [arc_pkg::STEP_W-1:0] step,
                                input logic [arc_pkg::FRAMES_W-1:0] count);
        write_reg(arc_pkg::REG_CHANNEL_COUNT, arc_pkg::CFG_DW'(channels));
        write_reg(arc_pkg::REG_EIGHT_BIT_INPUT, arc_pkg::CFG_DW'(bytes));
        write_reg(arc_pkg::REG_FRAC_STEP, arc_pkg::CFG_DW'(step));
        write_reg(arc_pkg::REG_OUTPUT_COUNT, arc_pkg::CFG_DW'(count));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(input logic sos, input logic [arc_pkg::SAMPLE_W-1:0] raw_a,
                              input logic [arc_pkg::SAMPLE_W-1:0] raw_b);
        int unsigned gap;
        if (beats_left == 0) begin
            beats_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        beats_left--;
        s_valid          <= 1'b1;
        s_start_of_sound <= sos;
        s_raw_first      <= raw_a;
        s_raw_second     <= raw_b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
        predict_frames(sos, raw_a, raw_b);
    endtask

    // wait for every predicted frame, then let a dropped beat finish its pass
    task automatic drain_frames();
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : check_frames
        pcm_frame_t want;
        if (aresetn === 1'b1 && m_ready && m_valid !== 1'b0) begin
            if (frames_due.size() == 0) begin
                log_mismatch($sformatf("unexpected beat first %h second %h last %b",
                                       m_out_first, m_out_second, m_last_frame));
            end else begin
                want = frames_due.pop_front();
                if (m_out_first !== want.first)
                    log_mismatch($sformatf("out_first expected %h got %h",
                                           want.first, m_out_first));
                if (m_out_second !== want.second)
                    log_mismatch($sformatf("out_second expected %h got %h",
                                           want.second, m_out_second));
                if (m_last_frame !== want.last)
                    log_mismatch($sformatf("last_frame expected %b got %b",
                                           want.last, m_last_frame));
            end
        end
    end

    initial begin : stall_receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_seen;
        mode       = RX_OPEN;
        mode_left  = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: m_ready <= 1'b1;
                    RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                    RX_RUNS: begin
                        if (stall_left != 0) begin
                            stall_left--;
                            m_ready <= 1'b0;
                        end else begin
                            m_ready <= 1'b1;
                            stall_left = $urandom_range(1, 12);
                        end
                    end
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // output_count resets to zero, so the first beat is dropped
    task automatic test_reset_defaults();
        send_frame(1'b1, 16'h4321, 16'h0000);
        drain_frames();
        write_reg(arc_pkg::REG_OUTPUT_COUNT, arc_pkg::CFG_DW'(3));
        cfg_wr_en <= 1'b0;
        send_frame(1'b1, 16'h8000, 16'hFFFF);
        send_frame(1'b0, 16'h7FFF, 16'h0000);
        send_frame(1'b0, 16'h0000, 16'h5555);
        // sound is over: these two are ignored
        send_frame(1'b0, 16'hFFFF, 16'hAAAA);
        send_frame(1'b0, 16'h1234, 16'h8001);
        drain_frames();
    endtask

    task automatic test_byte_stereo();
        apply_config(2'd2, 1'b1, 12'd512, 24'd3);
        send_frame(1'b1, 16'hAB00, 16'h12FF);
        send_frame(1'b0, 16'h0080, 16'hFF7F);
        send_frame(1'b0, 16'h5501, 16'hAAFE);
        drain_frames();
    endtask

    // step of 1.5 elements lands stereo frames on odd elements
    task automatic test_odd_stereo();
        apply_config(2'd2, 1'b0, 12'd384, 24'd6);
        send_frame(1'b1, 16'h1111, 16'h2222);
        send_frame(1'b0, 16'h3333, 16'hC444);
        send_frame(1'b0, 16'h5555, 16'h6666);
        send_frame(1'b0, 16'h7777, 16'h8888);
        drain_frames();
    endtask

    task automatic test_channel_clamp();
        apply_config(2'd0, 1'b0, 12'd128, 24'd5);
        send_frame(1'b1, 16'h0F0F, 16'hF0F0);
        send_frame(1'b0, 16'hF00D, 16'h0BAD);
        drain_frames();
        apply_config(2'd3, 1'b0, 12'd1024, 24'd2);
        send_frame(1'b1, 16'h0101, 16'h0202);
        send_frame(1'b0, 16'h0303, 16'h0404);
        send_frame(1'b0, 16'h0505, 16'h0606);
        drain_frames();
    endtask

    // stop the sound after one frame, then reopen it so the backlog exceeds a burst
    task automatic test_burst_limit();
        apply_config(2'd2, 1'b0, 12'd32, 24'd1);
        send_frame(1'b1, 16'hA001, 16'hA002);
        drain_frames();
        write_reg(arc_pkg::REG_OUTPUT_COUNT, 24'hFFFFFF);
        cfg_wr_en <= 1'b0;
        send_frame(1'b0, 16'hA003, 16'hA004);
        send_frame(1'b0, 16'hA005, 16'hA006);
        drain_frames();
        write_reg(arc_pkg::REG_FRAC_STEP, arc_pkg::CFG_DW'(2048));
        cfg_wr_en <= 1'b0;
        send_frame(1'b0, 16'hA007, 16'hA008);
        send_frame(1'b0, 16'hA009, 16'hA00A);
        drain_frames();
    endtask

    task automatic test_output_stall();
        apply_config(2'd2, 1'b0, 12'd64, 24'd500);
        send_frame(1'b1, 16'($urandom), 16'($urandom));
        hold_flip <= ~hold_flip;
        repeat (8) send_frame(1'b0, 16'($urandom), 16'($urandom));
        drain_frames();
    endtask

    function automatic logic [arc_pkg::STEP_W-1:0] pick_step();
        case ($urandom_range(0, 4))
            0:       return 12'd32;
            1:       return 12'd2048;
            2:       return 12'd256;
            default: return 12'($urandom_range(32, 2048));
        endcase
    endfunction

    task automatic test_random_sounds();
        int unsigned                  len;
        logic                         sos;
        logic [arc_pkg::FRAMES_W-1:0] count;
        while (items_sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       count = '0;
                    1:       count = 24'hFFFFFF;
                    default: count = 24'($urandom_range(1, 60));
                endcase
                apply_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             pick_step(), count);
            end else begin
                // retune the step in the middle of a sound
                write_reg(arc_pkg::REG_FRAC_STEP, arc_pkg::CFG_DW'(pick_step()));
                cfg_wr_en <= 1'b0;
            end
            len = $urandom_range(4, 14);
            for (int i = 0; i < len; i++) begin
                sos = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0);
                send_frame(sos, 16'($urandom), 16'($urandom));
            end
            drain_frames();
        end
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = arc_pkg::REG_CHANNEL_COUNT;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_start_of_sound = 1'b0;
        s_raw_first      = '0;
        s_raw_second     = '0;
        hold_flip        = 1'b0;
        items_sent       = 0;
        mismatches       = 0;
        beats_left       = 0;
        cfg_channels     = 2'd1;
        cfg_bytes        = 1'b0;
        cfg_step         = 12'd256;
        cfg_frames       = '0;
        clear_sound();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_byte_stereo();
        test_odd_stereo();
        test_channel_clamp();
        test_burst_limit();
        test_output_stall();
        test_random_sounds();

        drain_frames();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
